/* design/plcm_pkg.sv */
`default_nettype none

package plcm_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 17;
    localparam int CHAN_W   = 16;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int IDX_W    = 12;
    localparam int RES_W    = 13;
    localparam int STATUS_W = 2;

    // Stream widths: payload rounded up to whole bytes
    localparam int S_TDATA_W = 80;   // 77 bits of fields
    localparam int M_TDATA_W = 56;   // 50 bits of fields

    // One table entry: position above packed color (red high)
    localparam int ENTRY_W = POS_W + COLOR_W;

    localparam int MAX_POINTS_DEF = 16;
    localparam logic [RES_W-1:0] RES_RESET = 13'd256;
    localparam logic [POS_W-1:0] ONE_Q16   = 17'h10000;
    localparam int FRAC_BITS = 16;

    // Shared divider
    localparam int DIV_NUM_W = 28;   // (2*idx+1) << 15
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem0;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* design/piecewise_linear_color_map.sv */
// From input beat to result beat: clear, append and unused codes go straight to
//   the hand-off; a single-point evaluate fetches its point, blends and hands off; with
//   n >= 2 points an evaluate runs the density divide, segment walk, segment fetch,
//   fraction divide (skipped when the fraction is 0 or 1.0), channel blends, hand-off.
// Throughput: one item at a time, s_tready high only while idle; a finished result
//   may wait in the output register. Reset (sync, active low): empty table, res 256.
`default_nettype none

module piecewise_linear_color_map #(
    parameter int MAX_POINTS = plcm_pkg::MAX_POINTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [16:0] point_position, [32:17] point_red, [48:33] point_green,
    // [64:49] point_blue, [76:65] sample_index, [79:77] zero
    input  wire logic [plcm_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  wire logic [plcm_pkg::FUNC_W-1:0]     s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue, [49:48] status,
    // [55:50] zero
    output logic      [plcm_pkg::M_TDATA_W-1:0]  m_tdata,
    // texture_resolution write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [plcm_pkg::RES_W-1:0]      cfg_data
);

    import plcm_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int COUNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DENS,      // density divide running
        S_SRCH_RD,   // read position of k+1
        S_SRCH_CMP,  // step k while that position is at or below density
        S_RD_LO,
        S_RD_HI,
        S_CAP_HI,
        S_FRAC,      // pick fraction or start fraction divide
        S_FDIV,
        S_MUL,       // one channel: (hi - lo) * frac
        S_ACC,       // lo*2^16 + product, rounded
        S_DONE
    } state_t;

    // Input field decode
    logic [FUNC_W-1:0]  in_func;
    logic [POS_W-1:0]   in_pos;
    logic [CHAN_W-1:0]  in_red;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_blue;
    logic [IDX_W-1:0]   in_idx;
    logic [POS_W-1:0]   pos_clamped;

    assign in_func  = s_tuser;
    assign in_pos   = s_tdata[16:0];
    assign in_red   = s_tdata[32:17];
    assign in_green = s_tdata[48:33];
    assign in_blue  = s_tdata[64:49];
    assign in_idx   = s_tdata[76:65];
    assign pos_clamped = (in_pos > ONE_Q16) ? ONE_Q16 : in_pos;

    // Registers
    state_t                       state_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [RES_W-1:0]             res_cfg_reg;
    logic [ADDR_W-1:0]            k_reg;
    logic                         single_reg;
    logic [DIV_NUM_W-1:0]         dens_reg;
    logic [POS_W-1:0]             lo_pos_reg;
    logic [POS_W-1:0]             hi_pos_reg;
    logic [2:0][CHAN_W-1:0]       lo_col_reg;   // [2] red, [1] green, [0] blue
    logic [2:0][CHAN_W-1:0]       hi_col_reg;
    logic [POS_W-1:0]             frac_reg;     // 0..65536
    logic [1:0]                   ch_reg;
    logic signed [34:0]           prod_reg;
    logic [2:0][CHAN_W-1:0]       res_reg;
    logic [STATUS_W-1:0]          status_reg;
    logic                         m_tvalid_reg;
    logic [M_TDATA_W-1:0]         m_tdata_reg;
    logic                         div_start_reg;
    div_req_t                     div_req_reg;

    // Control
    logic                 in_beat;
    logic                 table_full;
    logic                 k_more;
    logic [RES_W-1:0]     res_eff;

    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_beat    = s_tvalid && s_tready;
    assign table_full = (count_reg == COUNT_W'(MAX_POINTS));
    assign k_more     = (COUNT_W'(k_reg) + COUNT_W'(2)) < count_reg;
    assign res_eff    = (res_cfg_reg == '0) ? RES_W'(1) : res_cfg_reg;

    // Point table
    logic                 wr_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic [POS_W-1:0]     rd_pos;
    logic [COLOR_W-1:0]   rd_col;

    assign wr_en  = in_beat && (in_func == FUNC_APPEND) && !table_full;
    assign rd_pos = rd_data[ENTRY_W-1:COLOR_W];
    assign rd_col = rd_data[COLOR_W-1:0];

    // Upper point of the segment is read in the search and in the second fetch
    always_comb begin
        rd_addr = k_reg;
        if (state_reg == S_SRCH_RD || state_reg == S_RD_HI) begin
            rd_addr = k_reg + ADDR_W'(1);
        end
    end

    plcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data ({pos_clamped, in_red, in_green, in_blue}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared divider: density first, fraction later
    logic                  div_busy;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_quo;

    plcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .req      (div_req_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Fraction selection
    logic                 dens_ge_lo;
    logic                 seg_flat;      // upper position not above lower
    logic [DIV_NUM_W-1:0] dens_off;
    logic [POS_W-1:0]     span;
    logic                 off_ge_span;

    assign dens_ge_lo  = dens_reg >= DIV_NUM_W'(lo_pos_reg);
    assign seg_flat    = hi_pos_reg <= lo_pos_reg;
    assign dens_off    = dens_reg - DIV_NUM_W'(lo_pos_reg);
    assign span        = hi_pos_reg - lo_pos_reg;
    assign off_ge_span = dens_off >= DIV_NUM_W'(span);

    // Channel blend: lo*(1-f) + hi*f == lo*2^16 + (hi-lo)*f
    logic [CHAN_W-1:0]    lo_ch;
    logic [CHAN_W-1:0]    hi_ch;
    logic signed [16:0]   diff_ch;
    logic signed [17:0]   frac_s;
    logic signed [34:0]   mul_prod;
    logic signed [35:0]   acc_sum;

    assign lo_ch    = lo_col_reg[ch_reg];
    assign hi_ch    = hi_col_reg[ch_reg];
    assign diff_ch  = signed'({1'b0, hi_ch}) - signed'({1'b0, lo_ch});
    assign frac_s   = signed'({1'b0, frac_reg});
    assign mul_prod = diff_ch * frac_s;
    assign acc_sum  = signed'({4'b0, lo_ch, 16'b0}) + 36'(prod_reg) + 36'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_cfg_reg   <= RES_RESET;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                res_cfg_reg <= cfg_data;
            end
            // hand-off state reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_beat) begin
                        res_reg <= '0;
                        k_reg   <= '0;
                        unique case (in_func)
                            FUNC_CLEAR: begin
                                count_reg  <= '0;
                                status_reg <= STATUS_OK;
                                single_reg <= 1'b0;
                                state_reg  <= S_DONE;
                            end
                            FUNC_APPEND: begin
                                single_reg <= 1'b0;
                                state_reg  <= S_DONE;
                                if (table_full) begin
                                    status_reg <= STATUS_FULL;
                                end else begin
                                    status_reg <= STATUS_OK;
                                    count_reg  <= count_reg + COUNT_W'(1);
                                end
                            end
                            FUNC_EVAL: begin
                                if (count_reg == '0) begin
                                    status_reg <= STATUS_EMPTY;
                                    single_reg <= 1'b0;
                                    state_reg  <= S_DONE;
                                end else if (count_reg == COUNT_W'(1)) begin
                                    status_reg <= STATUS_OK;
                                    single_reg <= 1'b1;
                                    state_reg  <= S_RD_LO;
                                end else begin
                                    // density = (2*idx+1) * 2^15 / res
                                    status_reg          <= STATUS_OK;
                                    single_reg          <= 1'b0;
                                    div_start_reg       <= 1'b1;
                                    div_req_reg.rem0    <= '0;
                                    div_req_reg.num     <= {in_idx, 1'b1, 15'b0};
                                    div_req_reg.divisor <= DIV_DEN_W'(res_eff);
                                    div_req_reg.steps   <= DIV_CNT_W'(DIV_NUM_W);
                                    state_reg           <= S_DENS;
                                end
                            end
                            default: begin
                                // unused code: no change, zero result
                                status_reg <= STATUS_OK;
                                single_reg <= 1'b0;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DENS: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        dens_reg  <= div_quo;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    state_reg <= k_more ? S_SRCH_CMP : S_RD_LO;
                end
                S_SRCH_CMP: begin
                    if (DIV_NUM_W'(rd_pos) <= dens_reg) begin
                        k_reg     <= k_reg + ADDR_W'(1);
                        state_reg <= S_SRCH_RD;
                    end else begin
                        state_reg <= S_RD_LO;
                    end
                end
                S_RD_LO: begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI: begin
                    lo_pos_reg <= rd_pos;
                    lo_col_reg <= rd_col;
                    if (single_reg) begin
                        // single point: blend with itself at fraction zero
                        hi_col_reg <= rd_col;
                        frac_reg   <= '0;
                        ch_reg     <= '0;
                        state_reg  <= S_MUL;
                    end else begin
                        state_reg  <= S_CAP_HI;
                    end
                end
                S_CAP_HI: begin
                    hi_pos_reg <= rd_pos;
                    hi_col_reg <= rd_col;
                    state_reg  <= S_FRAC;
                end
                S_FRAC: begin
                    ch_reg <= '0;
                    priority if (seg_flat) begin
                        frac_reg  <= dens_ge_lo ? ONE_Q16 : '0;
                        state_reg <= S_MUL;
                    end else if (!dens_ge_lo) begin
                        frac_reg  <= '0;
                        state_reg <= S_MUL;
                    end else if (off_ge_span) begin
                        frac_reg  <= ONE_Q16;
                        state_reg <= S_MUL;
                    end else begin
                        // offset < span: shift in 16 zero bits
                        div_start_reg       <= 1'b1;
                        div_req_reg.rem0    <= DIV_DEN_W'(dens_off);
                        div_req_reg.num     <= '0;
                        div_req_reg.divisor <= DIV_DEN_W'(span);
                        div_req_reg.steps   <= DIV_CNT_W'(FRAC_BITS);
                        state_reg           <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        frac_reg  <= {1'b0, div_quo[FRAC_BITS-1:0]};
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    res_reg[ch_reg] <= acc_sum[31:16];
                    if (ch_reg == 2'd2) begin
                        state_reg <= S_DONE;
                    end else begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE: begin
                    // output register free or emptying this cycle
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, status_reg, res_reg[0], res_reg[1], res_reg[2]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider is idle whenever the block can take a beat
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // Table never counts past its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_POINTS))
        else $error("point count out of range");

    // A result only appears from the hand-off state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside hand-off");

    // Evaluate on an empty table goes straight to hand-off
    a_empty_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && in_func == FUNC_EVAL && count_reg == '0) |=> (state_reg == S_DONE))
        else $error("empty evaluate did not finish at once");

endmodule

`default_nettype wire

/* design/plcm_ram.sv */
`default_nettype none

module plcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

/* design/plcm_div.sv */
`default_nettype none

module plcm_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire plcm_pkg::div_req_t                 req,
    output logic                                    busy,
    output logic                                    done,
    output logic [plcm_pkg::DIV_NUM_W-1:0]          quotient
);

    import plcm_pkg::*;

    // Restoring divide, one quotient bit per cycle. Remainder starts at
    // req.rem0 (must be below the divisor), numerator bits shift in MSB first.
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    assign trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : DIV_DEN_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= req.rem0;
                num_reg  <= req.num;
                den_reg  <= req.divisor;
                cnt_reg  <= req.steps;
                quo_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

// Checks piecewise_linear_color_map against a behavioral color-map predictor
// kept in this file. Every accepted input beat is pushed through the predictor;
// every result beat is compared field by field with the oldest expected color.

module testbench;
    import plcm_pkg::*;

    // Unused selector: not in the package since only the testbench drives it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int HOLD_CYCLES    = 500;   // receiver hold-off for the fill-up test
    localparam int PRINT_LIMIT    = 40;    // mismatch lines printed before going quiet

    // One input beat, unpacked
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [IDX_W-1:0]  idx;
    } map_op_t;

    // One result beat, unpacked
    typedef struct packed {
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [STATUS_W-1:0] status;
    } color_result_t;

    // DUT ports; every input known from time zero
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RES_W-1:0]     cfg_data  = '0;

    // Predictor copy of the block state
    logic [POS_W-1:0]   map_pos [MAX_POINTS_DEF];
    logic [COLOR_W-1:0] map_rgb [MAX_POINTS_DEF];
    int                 map_count = 0;
    logic [RES_W-1:0]   map_res   = RES_RESET;

    color_result_t color_queue[$];   // expected colors, oldest first
    int  mismatch_count = 0;
    int  items_sent     = 0;
    logic steady_flow   = 1'b0;      // both sides run without idling while set
    logic holding       = 1'b0;      // receiver hold-off in progress
    event hold_off_start;

    piecewise_linear_color_map dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Safety net: far beyond the slowest legal run
    initial begin
        #(8_000_000);
        $display("** piecewise_linear_color_map: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Blend of one channel by a Q1.16 fraction, rounded half up
    function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] lo,
                                                input logic [CHAN_W-1:0] hi,
                                                input logic [63:0] frac);
        logic [63:0] acc;
        acc = 64'(lo) * (64'd65536 - frac) + 64'(hi) * frac + 64'd32768;
        return acc[31:16];
    endfunction

    // Applies one beat to the predictor state and returns the expected result
    function automatic color_result_t predict_color(input map_op_t op);
        color_result_t res;
        logic [63:0] rdiv, dens, plo, phi, frac;
        int k;
        res = '0;
        case (op.func)
            FUNC_CLEAR: map_count = 0;
            FUNC_APPEND: begin
                if (map_count >= MAX_POINTS_DEF) begin
                    res.status = STATUS_FULL;
                end else begin
                    // positions past 1.0 saturate
                    map_pos[map_count] = (op.pos > ONE_Q16) ? ONE_Q16 : op.pos;
                    map_rgb[map_count] = {op.red, op.green, op.blue};
                    map_count++;
                end
            end
            FUNC_EVAL: begin
                if (map_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (map_count == 1) begin
                    {res.red, res.green, res.blue} = map_rgb[0];
                end else begin
                    // resolution 0 behaves as 1; density may exceed 1.0
                    rdiv = (map_res == '0) ? 64'd1 : 64'(map_res);
                    dens = ((64'(op.idx) * 2 + 64'd1) << 16) / (rdiv * 2);
                    k = 0;
                    while (k + 2 < map_count && 64'(map_pos[k + 1]) <= dens) k++;
                    plo = 64'(map_pos[k]);
                    phi = 64'(map_pos[k + 1]);
                    if (phi <= plo) begin
                        // flat or descending segment: step at the lower point
                        frac = (dens >= plo) ? 64'd65536 : 64'd0;
                    end else if (dens < plo) begin
                        frac = 64'd0;
                    end else begin
                        frac = ((dens - plo) << 16) / (phi - plo);
                        if (frac > 64'd65536) frac = 64'd65536;
                    end
                    res.red   = blend(map_rgb[k][47:32], map_rgb[k + 1][47:32], frac);
                    res.green = blend(map_rgb[k][31:16], map_rgb[k + 1][31:16], frac);
                    res.blue  = blend(map_rgb[k][15:0],  map_rgb[k + 1][15:0],  frac);
                end
            end
            default: ;   // unused selector: nothing changes
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random tready, hold-off, and the checker
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        color_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (color_queue.size() == 0) begin
                note_mismatch("result beat with nothing expected", m_tdata[15:0], 16'h0);
            end else begin
                want = color_queue.pop_front();
                if (m_tdata[15:0] !== want.red)
                    note_mismatch("out_red", m_tdata[15:0], want.red);
                if (m_tdata[31:16] !== want.green)
                    note_mismatch("out_green", m_tdata[31:16], want.green);
                if (m_tdata[47:32] !== want.blue)
                    note_mismatch("out_blue", m_tdata[47:32], want.blue);
                if (m_tdata[49:48] !== want.status)
                    note_mismatch("status", 16'(m_tdata[49:48]), 16'(want.status));
            end
        end
        // random tready low about 16 percent of the time, never in steady stretches
        m_tready <= !holding && (steady_flow || $urandom_range(0, 99) >= 16);
    end

    // Long receiver hold-off, counted here so the sender can keep pushing
    initial forever begin
        @(hold_off_start);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // All fields random; callers override what matters
    function automatic map_op_t random_op(input logic [FUNC_W-1:0] func);
        map_op_t op;
        op.func  = func;
        op.pos   = 17'($urandom);
        op.red   = 16'($urandom);
        op.green = 16'($urandom);
        op.blue  = 16'($urandom);
        op.idx   = 12'($urandom);
        return op;
    endfunction

    // Offers one beat after a random gap; returns at the accepting edge with
    // tvalid still high so a following beat can go out back to back
    task automatic send_item(input map_op_t op);
        int gap;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(0, 99) < 16) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.func;
        s_tdata  <= {3'b000, op.idx, op.blue, op.green, op.red, op.pos};
        do @(posedge aclk); while (!s_tready);
        color_queue.insert(color_queue.size(), predict_color(op));
        if (op.func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic simple_op(input logic [FUNC_W-1:0] func);
        send_item(random_op(func));
    endtask

    task automatic push_point(input logic [POS_W-1:0] pos, input logic [15:0] red,
                              input logic [15:0] green, input logic [15:0] blue);
        map_op_t op;
        op       = random_op(FUNC_APPEND);
        op.pos   = pos;
        op.red   = red;
        op.green = green;
        op.blue  = blue;
        send_item(op);
    endtask

    task automatic eval_sample(input logic [IDX_W-1:0] idx);
        map_op_t op;
        op     = random_op(FUNC_EVAL);
        op.idx = idx;
        send_item(op);
    endtask

    // Drops tvalid and waits until every expected result has been taken;
    // always waits on a clock edge, even with nothing pending
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (color_queue.size() != 0);
    endtask

    // Register write, only with the block idle
    task automatic set_resolution(input logic [RES_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        map_res = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table, unused selector, single point with position past 1.0
    task automatic test_empty_and_single();
        eval_sample(12'd0);
        simple_op(FUNC_UNUSED);
        push_point(17'h1FFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        eval_sample(12'hFFF);
        simple_op(FUNC_CLEAR);
    endtask

    // Sixteen points then one too many. Ladder opens with a descending pair
    // and closes with two points that both land at 1.0, one by saturation.
    task automatic test_full_table();
        logic [POS_W-1:0] ladder [MAX_POINTS_DEF];
        ladder = '{17'h00800, 17'h00400, 17'h01000, 17'h04000, 17'h05000, 17'h06000,
                   17'h07000, 17'h08000, 17'h09000, 17'h0A000, 17'h0B000, 17'h0C000,
                   17'h0D000, 17'h0E000, 17'h1FFFF, 17'h10000};
        for (int i = 0; i < MAX_POINTS_DEF; i++)
            push_point(ladder[i], (i % 2) ? 16'hFFFF : 16'h0000, 16'(i * 4369),
                       (i % 2) ? 16'h0000 : 16'hFFFF);
        push_point(17'h00000, 16'h1234, 16'h5678, 16'h9ABC);   // table full
        eval_sample(12'd0);      // below the descending first segment
        eval_sample(12'd20);     // inside an ordinary segment
        eval_sample(12'hFFF);    // far past 1.0, flat last segment
    endtask

    // Resolution extremes against the full table
    task automatic test_resolution_extremes();
        set_resolution(13'd0);
        eval_sample(12'd0);
        set_resolution(13'h1FFF);
        eval_sample(12'hFFF);
        set_resolution(13'd4096);
        eval_sample(12'hFFF);
        set_resolution(13'd1);
        eval_sample(12'd0);
    endtask

    // Receiver stalls while the sender keeps offering evaluations
    task automatic test_backpressure();
        set_resolution(RES_RESET);
        simple_op(FUNC_CLEAR);
        push_point(17'h00000, 16'h0000, 16'h0000, 16'h0000);
        push_point(17'h10000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        -> hold_off_start;
        for (int i = 0; i < 8; i++)
            eval_sample(12'($urandom_range(0, 255)));
        wait_drained();
    endtask

    // Well-formed tables with random content, plus broken and stray beats
    task automatic test_random_tables();
        int phase, npts, nevals, pos, prev, span, eff_res;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            steady_flow <= (phase >= 8 && phase < 20);
            if (phase % 4 == 0) begin
                case ($urandom_range(0, 5))
                    0: set_resolution(13'd0);
                    1: set_resolution(13'd1);
                    2: set_resolution(13'd4096);
                    3: set_resolution(13'h1FFF);
                    4: set_resolution(13'($urandom_range(1, 4096)));
                    default: set_resolution(13'($urandom_range(1, 64)));
                endcase
            end
            // occasionally keep the old table so appends stack up to full
            if ($urandom_range(0, 9) != 0) simple_op(FUNC_CLEAR);
            npts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(2, 6);
            span = 2 * 65536 / (npts + 1);
            prev = $urandom_range(0, 32768);
            for (int i = 0; i < npts; i++) begin
                case ($urandom_range(0, 9))
                    0: pos = $urandom_range(0, 17'h1FFFF);   // out of order or past 1.0
                    1: pos = prev;                           // repeated position
                    default: begin
                        pos = prev + $urandom_range(0, span);
                        if (pos > 65536) pos = 65536;
                    end
                endcase
                push_point(17'(pos), 16'($urandom), 16'($urandom), 16'($urandom));
                prev = (pos > 65536) ? 65536 : pos;
            end
            eff_res = (map_res == '0) ? 1 : int'(map_res);
            nevals = $urandom_range(3, 12);
            for (int i = 0; i < nevals; i++) begin
                case ($urandom_range(0, 19))
                    0: simple_op(FUNC_UNUSED);
                    1: push_point(17'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                    2, 3: eval_sample(12'($urandom));
                    default: eval_sample(12'($urandom_range(0, (eff_res > 4096) ? 4095
                                                                               : eff_res - 1)));
                endcase
            end
            phase++;
        end
        steady_flow <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_and_single();
        test_full_table();
        test_resolution_extremes();
        test_backpressure();
        test_random_tables();
        wait_drained();
        // any stray beat still in flight shows up here
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** piecewise_linear_color_map: PASSED **");
        end else begin
            $display("** piecewise_linear_color_map: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
design/plcm_pkg.sv
design/plcm_ram.sv
design/plcm_div.sv
design/piecewise_linear_color_map.sv
test/testbench.sv
